[hdl/linear_probe_hash_set_160_macros.svh]
// Assertion macros used by the hash set top level.
`ifndef LINEAR_PROBE_HASH_SET_160_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_160_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define LPHS_ASSERT_CLK(lbl, c, r, p) \
	lbl: assert property (@(posedge c) disable iff (!r) p) \
		else $error("lphs assertion failed");
// Concurrent assertion on the block clock and reset.
`define LPHS_ASSERT(lbl, p) `LPHS_ASSERT_CLK(lbl, clk, arst_n, p)
`else
`define LPHS_ASSERT_CLK(lbl, c, r, p)
`define LPHS_ASSERT(lbl, p)
`endif
`endif

[hdl/lphs_pkg.sv]
// Package with constants and control types of the hash set.
package lphs_pkg;
	localparam int SLOTS      = 512;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int KEY_W      = 160;
	localparam int KEY_BYTES  = KEY_W / 8;
	localparam int BYTE_W     = $clog2(KEY_BYTES);
	localparam int CNT_W      = 10;
	localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
	// The prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
	localparam int          FNV_SHIFT  = 40;
	localparam logic [8:0]  FNV_LOW    = 9'h1b3;
	localparam logic [CNT_W-1:0] FILL_RESET = 10'd256;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;
		logic load_key;
		logic hash_en;
		logic probe_init;
		logic mem_rd;
		logic probe_next;
		logic mem_wr;
		logic res_en;
	} lphs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic hit;
		logic empty;
		logic wrapped;
		logic is_query;
		logic room;
	} lphs_sts_t;
endpackage

[hdl/lphs_ram.sv]
// Generic single-port RAM with registered read.
module lphs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

[hdl/lphs_datapath.sv]
// Datapath: key register, serial hash, probe counters, slot memory and result.
module lphs_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lphs_pkg::lphs_cmd_t         cmd_i,
	output lphs_pkg::lphs_sts_t         sts,
	input  logic                        cmd,
	input  logic [63:0]                 key_low,
	input  logic [63:0]                 key_mid,
	input  logic [31:0]                 key_high,
	input  logic [lphs_pkg::CNT_W-1:0]  fill_limit,
	output logic                        done,
	output logic                        present,
	output logic                        inserted,
	output logic                        full_res
);
	logic [lphs_pkg::KEY_W-1:0]  key_q;
	logic                        query_q;
	logic [63:0]                 hash_q;
	logic [lphs_pkg::BYTE_W-1:0] byte_q;
	logic [lphs_pkg::IDX_W-1:0]  idx_q;
	logic [lphs_pkg::IDX_W-1:0]  pcnt_q;
	logic [lphs_pkg::IDX_W-1:0]  clr_q;
	logic [lphs_pkg::CNT_W-1:0]  used_q;
	logic                        done_q;
	logic                        present_q;
	logic                        inserted_q;
	logic                        full_q;
	logic [63:0]                 hx;
	logic [63:0]                 hash_next;
	logic [lphs_pkg::KEY_W-1:0]  rdata;
	logic [lphs_pkg::IDX_W-1:0]  addr;
	logic [lphs_pkg::KEY_W-1:0]  wdata;

	// One FNV-1a byte step: xor the byte in, multiply by the prime.
	always_comb begin
		hx        = hash_q ^ {56'd0, key_q[byte_q*8 +: 8]};
		hash_next = (hx << lphs_pkg::FNV_SHIFT) + 64'(hx * {55'd0, lphs_pkg::FNV_LOW});
	end

	// Key, hash and probe registers.
	always_ff @(posedge clk) begin
		if (cmd_i.load_key) begin
			key_q   <= {key_high, key_mid, key_low};
			query_q <= cmd;
			hash_q  <= lphs_pkg::FNV_OFFSET;
		end else if (cmd_i.hash_en) begin
			hash_q <= hash_next;
		end
		if (cmd_i.probe_init) begin
			idx_q <= hash_q[lphs_pkg::IDX_W-1:0];
		end else if (cmd_i.probe_next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Control counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q     <= '0;
			pcnt_q     <= '0;
			clr_q      <= '0;
			used_q     <= '0;
			done_q     <= 1'b0;
			present_q  <= 1'b0;
			inserted_q <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			if (cmd_i.load_key) begin
				byte_q <= '0;
			end else if (cmd_i.hash_en) begin
				byte_q <= byte_q + 1'b1;
			end
			if (cmd_i.probe_init) begin
				pcnt_q <= '0;
			end else if (cmd_i.probe_next) begin
				pcnt_q <= pcnt_q + 1'b1;
			end
			if (cmd_i.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_i.mem_wr) begin
				used_q <= used_q + 1'b1;
			end
			done_q <= cmd_i.res_en;
			if (cmd_i.res_en) begin
				present_q  <= sts.hit;
				inserted_q <= cmd_i.mem_wr;
				full_q     <= !sts.hit && !query_q && !cmd_i.mem_wr;
			end
		end
	end

	// Slot memory, swept to zero after reset.
	assign addr  = cmd_i.clr_en ? clr_q : idx_q;
	assign wdata = cmd_i.clr_en ? '0 : key_q;

	lphs_ram #(
		.WIDTH(lphs_pkg::KEY_W),
		.DEPTH(lphs_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (cmd_i.clr_en || cmd_i.mem_wr),
		.re   (cmd_i.mem_rd),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	// Status toward the controller.
	always_comb begin
		sts.clr_done  = (clr_q == lphs_pkg::IDX_W'(lphs_pkg::SLOTS - 1));
		sts.hash_done = (byte_q == lphs_pkg::BYTE_W'(lphs_pkg::KEY_BYTES - 1));
		sts.hit       = (rdata == key_q);
		sts.empty     = (rdata == '0);
		sts.wrapped   = (pcnt_q == lphs_pkg::IDX_W'(lphs_pkg::SLOTS - 1));
		sts.is_query  = query_q;
		sts.room      = ({1'b0, used_q} + 11'd1) <= {1'b0, fill_limit};
	end

	assign done     = done_q;
	assign present  = present_q;
	assign inserted = inserted_q;
	assign full_res = full_q;
endmodule

[hdl/lphs_ctrl.sv]
// Controller state machine of the hash set.
module lphs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lphs_pkg::lphs_sts_t sts,
	output lphs_pkg::lphs_cmd_t cmd_o
);
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_INIT  = 6'b001000,
		ST_READ  = 6'b010000,
		ST_CMP   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd_o   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd_o.clr_en = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd_o.load_key = 1'b1;
					state_d        = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd_o.hash_en = 1'b1;
				if (sts.hash_done) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd_o.probe_init = 1'b1;
				state_d          = ST_READ;
			end
			ST_READ: begin
				cmd_o.mem_rd = 1'b1;
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				priority if (sts.hit) begin
					cmd_o.res_en = 1'b1;
					state_d      = ST_IDLE;
				end else if (sts.empty) begin
					cmd_o.mem_wr = !sts.is_query && sts.room;
					cmd_o.res_en = 1'b1;
					state_d      = ST_IDLE;
				end else if (sts.wrapped) begin
					cmd_o.res_en = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd_o.probe_next = 1'b1;
					state_d          = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
endmodule

[hdl/linear_probe_hash_set_160.sv]
// Top level of the 160-bit key hash set with linear probing.
// After reset the block clears its 512-slot table, one slot a cycle, and
// holds busy high while it does so. An item is taken when start is high
// and busy low; it then hashes the key one byte a cycle, seeds the probe,
// and probes slot after slot (memory read, compare) until it finds the
// key or an empty slot, or has visited every slot. The result appears on
// done for one cycle, in the same cycle that busy falls, and the next item
// may be started in that same cycle. The result cannot be held off.
`include "linear_probe_hash_set_160_macros.svh"
module linear_probe_hash_set_160 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [63:0] key_low,
	input  logic [63:0] key_mid,
	input  logic [31:0] key_high,
	output logic        done,
	output logic        present,
	output logic        inserted,
	output logic        full_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	lphs_pkg::lphs_cmd_t        ctl_cmd;
	lphs_pkg::lphs_sts_t        ctl_sts;
	logic [lphs_pkg::CNT_W-1:0] fill_q;

	// Fill limit register on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= lphs_pkg::FILL_RESET;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			fill_q <= pwdata[lphs_pkg::CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {22'd0, fill_q} : 32'd0;

	lphs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (ctl_sts),
		.cmd_o (ctl_cmd)
	);

	lphs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_i     (ctl_cmd),
		.sts       (ctl_sts),
		.cmd       (cmd),
		.key_low   (key_low),
		.key_mid   (key_mid),
		.key_high  (key_high),
		.fill_limit(fill_q),
		.done      (done),
		.present   (present),
		.inserted  (inserted),
		.full_res  (full_res)
	);

	`LPHS_ASSERT(a_one_outcome, done |-> $countones({present, inserted, full_res}) <= 1)
	`LPHS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
	`LPHS_ASSERT(a_done_after_busy, done |-> $past(busy))
endmodule

[bench/tb_linear_probe_hash_set_160.sv]
// Testbench for the linear probing hash set of 160-bit keys.
`timescale 1ns / 100ps

module tb_linear_probe_hash_set_160;
	localparam logic       CMD_INSERT      = 1'b0;
	localparam logic       CMD_QUERY       = 1'b1;
	localparam logic [2:0] ADDR_FILL_LIMIT = 3'd0;
	localparam int         STALL_LIMIT     = 5000;

	typedef struct packed {
		logic         op;
		logic [159:0] key;
	} set_item_t;

	typedef struct packed {
		logic present;
		logic inserted;
		logic full_res;
	} set_answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [63:0] key_low;
	logic [63:0] key_mid;
	logic [31:0] key_high;
	logic        done;
	logic        present;
	logic        inserted;
	logic        full_res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	linear_probe_hash_set_160 DUT (.*);

	// Shadow copy of the set held by the block.
	logic [159:0]               shadow_slots [lphs_pkg::SLOTS];
	logic [lphs_pkg::CNT_W-1:0] shadow_count;
	logic [lphs_pkg::CNT_W-1:0] shadow_limit;

	set_item_t    pending_items [$];
	set_answer_t  answers_due [$];
	logic [159:0] known_keys [$];
	set_item_t    cur_item;
	int           gap_left;
	bit           gaps_on;
	bit           failed;
	int           quiet_cycles;

	// Clock generator.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// FNV-1a over the 20 key bytes, byte 0 first.
	function automatic logic [63:0] fnv_hash(logic [159:0] key);
		logic [63:0] h;
		h = 64'hcbf29ce484222325;
		for (int b = 0; b < 20; b++) begin
			h = h ^ {56'd0, key[8*b +: 8]};
			h = h * 64'h00000100000001b3;
		end
		return h;
	endfunction

	// Applies one item to the shadow set and returns the answer it must give.
	function automatic set_answer_t apply_item(set_item_t it);
		set_answer_t ans;
		int          idx;
		bit          has_free;
		int          free_idx;
		ans = '0;
		has_free = 0;
		free_idx = 0;
		idx = int'(fnv_hash(it.key) % lphs_pkg::SLOTS);
		for (int i = 0; i < lphs_pkg::SLOTS; i++) begin
			if (shadow_slots[idx] == it.key) begin
				ans.present = 1'b1;
				return ans;
			end
			if (shadow_slots[idx] == '0) begin
				has_free = 1;
				free_idx = idx;
				break;
			end
			idx = (idx + 1) % lphs_pkg::SLOTS;
		end
		if (it.op == CMD_QUERY)
			return ans;
		if ({1'b0, shadow_count} + 11'd1 > {1'b0, shadow_limit} || !has_free) begin
			ans.full_res = 1'b1;
			return ans;
		end
		shadow_slots[free_idx] = it.key;
		shadow_count = shadow_count + 1'b1;
		ans.inserted = 1'b1;
		return ans;
	endfunction

	function automatic logic [159:0] fresh_key();
		logic [159:0] k;
		k = {$urandom, $urandom, $urandom, $urandom, $urandom};
		known_keys.push_back(k);
		return k;
	endfunction

	// Mostly keys seen before or new ones, now and then the all-zero key.
	function automatic logic [159:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 50 && known_keys.size() > 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return fresh_key();
	endfunction

	function automatic void add_item(logic op, logic [159:0] key);
		set_item_t it;
		it.op = op;
		it.key = key;
		pending_items.push_back(it);
	endfunction

	function automatic void add_random(int n);
		for (int i = 0; i < n; i++)
			add_item(logic'($urandom_range(0, 1)), pick_key());
	endfunction

	// Item driver: an accepted item is predicted at the edge that takes it.
	always @(posedge clk) begin
		logic next_start;
		next_start = start;
		if (start && !busy) begin
			answers_due.push_back(apply_item(cur_item));
			next_start = 1'b0;
		end
		if (!next_start) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				if (gaps_on && $urandom_range(0, 3) == 0) begin
					gap_left = $urandom_range(0, 7);
				end else begin
					cur_item = pending_items.pop_front();
					cmd <= cur_item.op;
					{key_high, key_mid, key_low} <= cur_item.key;
					next_start = 1'b1;
				end
			end
		end
		start <= next_start;
	end

	// Result monitor.
	always @(posedge clk) begin
		set_answer_t want;
		if (done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: result with none expected: present %b inserted %b full %b",
					$time, present, inserted, full_res);
				failed = 1;
			end else begin
				want = answers_due.pop_front();
				if (want.present !== present) begin
					$display("%0t: present expected %b actual %b", $time, want.present, present);
					failed = 1;
				end
				if (want.inserted !== inserted) begin
					$display("%0t: inserted expected %b actual %b", $time, want.inserted,
						inserted);
					failed = 1;
				end
				if (want.full_res !== full_res) begin
					$display("%0t: full_res expected %b actual %b", $time, want.full_res,
						full_res);
					failed = 1;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_linear_probe_hash_set_160: FAIL");
			$finish;
		end
	end

	// Checked at the falling edge, once the driver's updates have settled.
	task automatic wait_idle();
		while (pending_items.size() > 0 || answers_due.size() > 0 || start)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_fill_limit(logic [lphs_pkg::CNT_W-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FILL_LIMIT;
		pwdata <= {22'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_limit = value;
		@(posedge clk);
	endtask

	// Stimulus phases.
	initial begin
		logic [159:0] k;
		start = 1'b0;
		cmd = CMD_INSERT;
		key_low = '0;
		key_mid = '0;
		key_high = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_left = 0;
		gaps_on = 1;
		failed = 0;
		quiet_cycles = 0;
		for (int i = 0; i < lphs_pkg::SLOTS; i++)
			shadow_slots[i] = '0;
		shadow_count = '0;
		shadow_limit = lphs_pkg::FILL_RESET;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset fill limit.
		add_item(CMD_QUERY, '0);
		add_item(CMD_INSERT, '0);
		add_item(CMD_QUERY, {160{1'b1}});
		add_item(CMD_INSERT, {160{1'b1}});
		add_item(CMD_INSERT, {160{1'b1}});
		add_item(CMD_QUERY, {160{1'b1}});
		add_item(CMD_INSERT, {32'hffffffff, 128'd0});
		add_item(CMD_INSERT, {32'd0, {64{1'b1}}, 64'd0});
		add_item(CMD_INSERT, {96'd0, {64{1'b1}}});
		add_item(CMD_INSERT, 160'd1);
		k = fresh_key();
		add_item(CMD_QUERY, k);
		add_item(CMD_INSERT, k);
		add_item(CMD_QUERY, k);

		// A zero limit refuses every absent key.
		write_fill_limit(10'd0);
		add_item(CMD_INSERT, fresh_key());
		add_item(CMD_INSERT, {160{1'b1}});
		add_item(CMD_QUERY, k);
		write_fill_limit(10'd1);
		add_item(CMD_INSERT, fresh_key());
		add_item(CMD_INSERT, k);

		// Random traffic that runs into the limit.
		write_fill_limit(10'd300);
		add_random(480);
		write_fill_limit(10'd512);
		add_random(280);

		// Fill every slot, then probe a table without an empty slot.
		write_fill_limit(10'h3ff);
		wait_idle();
		gaps_on = 0;
		for (int i = 0; i < lphs_pkg::SLOTS - int'(shadow_count) + 5; i++)
			add_item(CMD_INSERT, fresh_key());
		wait_idle();
		gaps_on = 1;
		for (int i = 0; i < 20; i++) begin
			add_item(CMD_QUERY, fresh_key());
			add_item(CMD_QUERY, known_keys[$urandom_range(0, known_keys.size() - 1)]);
		end
		add_item(CMD_INSERT, fresh_key());
		add_item(CMD_QUERY, '0);

		// Last part without idling.
		write_fill_limit(10'd5);
		wait_idle();
		gaps_on = 0;
		add_random(200);

		wait_idle();
		repeat (50) @(posedge clk);
		if (!failed)
			$display("tb_linear_probe_hash_set_160: PASS");
		else
			$display("tb_linear_probe_hash_set_160: FAIL");
		$finish;
	end
endmodule

[linear_probe_hash_set_160.f]
+incdir+hdl
hdl/lphs_pkg.sv
hdl/lphs_ram.sv
hdl/lphs_datapath.sv
hdl/lphs_ctrl.sv
hdl/linear_probe_hash_set_160.sv
bench/tb_linear_probe_hash_set_160.sv
